>>> src/qsg_pkg.sv
// shared widths, register codes, beat types and the arctangent table for the quadrature nco
package qsg_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int CORDIC_STAGES = 18;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int AMP_W   = 18;
    localparam int OUT_W   = 18;
    localparam int TURN_W  = 32;
    localparam int Z_W     = 32;
    localparam int XY_W    = 33;
    localparam int PROD_W  = AMP_W + XY_W;
    localparam int CFG_IDX_W = 2;

    localparam int ROUND_SHIFT = 30;
    localparam int OUT_MAX     = 131071;

    localparam logic signed [XY_W-1:0] GAIN_START = XY_W'(652032874);
    localparam logic signed [AMP_W-1:0] AMP_RESET = AMP_W'(65536);

    // total cycles from accepted beat to result strobe
    localparam int LATENCY = CORDIC_STAGES + 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP   = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        quad;
        logic [Z_W-1:0]    z;
    } t_phase_beat;

    typedef struct packed {
        logic                   valid;
        logic [1:0]             quad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } t_vec_beat;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [Z_W-1:0] atan_step(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/qsg_phase.sv
// phase computation stages: time times frequency word, offset add, quadrant split
module qsg_phase import qsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [TIME_W-1:0] i_time,
    input  logic [CFG_W-1:0]  i_freq,
    input  logic [CFG_W-1:0]  i_offset,
    output t_phase_beat       o_beat
);

    logic                    r_s1_valid;
    logic [PHASE_BITS-1:0]   r_prod;
    logic [2*TIME_W-1:0]     w_prod_full;
    logic [PHASE_BITS-1:0]   w_phase;
    logic [TURN_W-1:0]       w_turn;
    logic [TURN_W-1:0]       w_round;
    logic [1:0]              w_quad;
    t_phase_beat             r_beat;
    t_phase_beat             n_beat;

    assign w_prod_full = i_time * i_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_prod <= w_prod_full[PHASE_BITS-1:0];
    end

    assign w_phase = r_prod + PHASE_BITS'(i_offset);

    // bring the phase to 32 bits of a turn
    if (PHASE_BITS >= TURN_W) begin : g_narrow
        assign w_turn = w_phase[PHASE_BITS-1 -: TURN_W];
    end else begin : g_widen
        assign w_turn = {w_phase, {(TURN_W-PHASE_BITS){1'b0}}};
    end

    // nearest quarter turn, residual in [-1/8, 1/8) turn
    assign w_round = w_turn + TURN_W'(32'h2000_0000);
    assign w_quad  = w_round[TURN_W-1 -: 2];

    always_comb begin
        n_beat.valid = r_s1_valid;
        n_beat.quad  = w_quad;
        n_beat.z     = w_turn - {w_quad, {(TURN_W-2){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

    a_residual_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat.valid |-> (r_beat.z[Z_W-1] == r_beat.z[Z_W-2])
                      && (r_beat.z[Z_W-2] == r_beat.z[Z_W-3]))
        else $error("residual angle outside one eighth turn");

endmodule

>>> src/qsg_cordic.sv
// rotation mode cordic, one register stage per micro-rotation
module qsg_cordic import qsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_phase_beat i_beat,
    output t_vec_beat   o_beat
);

    typedef struct packed {
        logic                   valid;
        logic [1:0]             quad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
    } t_rot_beat;

    t_rot_beat r_st [CORDIC_STAGES];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        t_rot_beat              w_in;
        t_rot_beat              n_st;
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;

        if (g == 0) begin : g_first
            always_comb begin
                w_in.valid = i_beat.valid;
                w_in.quad  = i_beat.quad;
                w_in.x     = GAIN_START;
                w_in.y     = '0;
                w_in.z     = i_beat.z;
            end
        end else begin : g_next
            assign w_in = r_st[g-1];
        end

        assign w_dx = w_in.y >>> g;
        assign w_dy = w_in.x >>> g;

        always_comb begin
            n_st = w_in;
            // zero residual counts as positive
            if (!w_in.z[Z_W-1]) begin
                n_st.x = w_in.x - w_dx;
                n_st.y = w_in.y + w_dy;
                n_st.z = w_in.z - atan_step(g);
            end else begin
                n_st.x = w_in.x + w_dx;
                n_st.y = w_in.y - w_dy;
                n_st.z = w_in.z + atan_step(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g].valid <= 1'b0;
            end else begin
                r_st[g] <= n_st;
            end
        end
    end

    always_comb begin
        o_beat.valid = r_st[CORDIC_STAGES-1].valid;
        o_beat.quad  = r_st[CORDIC_STAGES-1].quad;
        o_beat.x     = r_st[CORDIC_STAGES-1].x;
        o_beat.y     = r_st[CORDIC_STAGES-1].y;
    end

    // residual within one eighth turn keeps the cosine clearly positive
    a_cos_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st[CORDIC_STAGES-1].valid |-> !r_st[CORDIC_STAGES-1].x[XY_W-1])
        else $error("cordic cosine went negative");

endmodule

>>> src/qsg_scale.sv
// quadrant mapping, amplitude multiply, rounding and saturation to q1.16
module qsg_scale import qsg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_vec_beat               i_beat,
    input  logic signed [AMP_W-1:0] i_amp,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_real,
    output logic signed [OUT_W-1:0] o_imag
);

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(OUT_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI;
    localparam logic signed [PROD_W-1:0] BIAS   = PROD_W'(64'd1 << (ROUND_SHIFT - 1));

    typedef struct packed {
        logic                   valid;
        logic signed [XY_W-1:0] c;
        logic signed [XY_W-1:0] s;
    } t_sel_beat;

    typedef struct packed {
        logic                     valid;
        logic signed [PROD_W-1:0] pc;
        logic signed [PROD_W-1:0] ps;
    } t_mul_beat;

    t_sel_beat               r_sel;
    t_sel_beat               n_sel;
    t_mul_beat               r_mul;
    t_mul_beat               n_mul;
    logic                    r_valid;
    logic signed [OUT_W-1:0] r_real;
    logic signed [OUT_W-1:0] r_imag;

    function automatic logic signed [OUT_W-1:0] sat_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sum;
        logic signed [PROD_W-1:0] shf;
        logic signed [OUT_W-1:0]  res;
        sum = p + BIAS;
        shf = sum >>> ROUND_SHIFT;
        if (shf > SAT_HI) begin
            res = OUT_W'(SAT_HI);
        end else if (shf < SAT_LO) begin
            res = OUT_W'(SAT_LO);
        end else begin
            res = OUT_W'(shf);
        end
        return res;
    endfunction

    always_comb begin
        n_sel.valid = i_beat.valid;
        case (i_beat.quad)
            2'd0: begin
                n_sel.c = i_beat.x;
                n_sel.s = i_beat.y;
            end
            2'd1: begin
                n_sel.c = -i_beat.y;
                n_sel.s = i_beat.x;
            end
            2'd2: begin
                n_sel.c = -i_beat.x;
                n_sel.s = -i_beat.y;
            end
            default: begin
                n_sel.c = i_beat.y;
                n_sel.s = -i_beat.x;
            end
        endcase
    end

    always_comb begin
        n_mul.valid = r_sel.valid;
        n_mul.pc    = i_amp * r_sel.c;
        n_mul.ps    = i_amp * r_sel.s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel.valid <= 1'b0;
            r_mul.valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_sel   <= n_sel;
            r_mul   <= n_mul;
            r_valid <= r_mul.valid;
        end
        r_real <= sat_round(r_mul.pc);
        r_imag <= sat_round(r_mul.ps);
    end

    assign o_valid = r_valid;
    assign o_real  = r_real;
    assign o_imag  = r_imag;

    a_real_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_real <= OUT_W'(OUT_MAX)) && (r_real >= -OUT_W'(OUT_MAX)))
        else $error("real part escaped saturation");

    a_imag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_imag <= OUT_W'(OUT_MAX)) && (r_imag >= -OUT_W'(OUT_MAX)))
        else $error("imag part escaped saturation");

endmodule

>>> src/quadrature_sine_generator_core.sv
// top level of the quadrature nco: configuration registers and the phase, cordic, scale pipeline
//
// usage:
//   input beat: drive i_time_tick with start high; it is taken at any edge where busy
//   is low. busy never rises, so a new time sample can enter on every clock cycle.
//   result beat: o_valid strobes for one cycle with o_real_part = A*cos and
//   o_imag_part = A*sin of the phase (time_tick * frequency_word + phase_offset).
//   results leave in input order, one per input beat, and must be taken in that
//   cycle: there is no backpressure from the receiver.
//   pipeline: CORDIC_STAGES + 5 register stages (23 at 18 stages) from the accept
//   edge to the strobe: a register after the 32x32 phase multiply, one after offset
//   add and quadrant split, one per cordic micro-rotation, then the quadrant map,
//   amplitude multiply and round registers.
//   throughput: one beat per cycle, set by the fully pipelined cordic chain.
//   configuration: write index 0 frequency word, 1 phase offset, 2 amplitude
//   (low 18 bits, q1.16) over the cfg channel; o_cfg_ready is always high and
//   other indexes are dropped. write only while the pipeline is empty.
//   reset: synchronous, active low; clears all valid bits in flight and loads
//   frequency 0, offset 0 and amplitude 1.0.
module quadrature_sine_generator_core import qsg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [TIME_W-1:0]       i_time_tick,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_real_part,
    output logic signed [OUT_W-1:0] o_imag_part,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    logic [CFG_W-1:0]        r_freq;
    logic [CFG_W-1:0]        r_offset;
    logic signed [AMP_W-1:0] r_amp;
    logic                    w_accept;
    t_phase_beat             w_phase;
    t_vec_beat               w_vec;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= '0;
            r_offset <= '0;
            r_amp    <= AMP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FREQ:  r_freq   <= i_cfg_data;
                CFG_PHASE: r_offset <= i_cfg_data;
                CFG_AMP:   r_amp    <= i_cfg_data[AMP_W-1:0];
                default:   ;
            endcase
        end
    end

    qsg_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_time   (i_time_tick),
        .i_freq   (r_freq),
        .i_offset (r_offset),
        .o_beat   (w_phase)
    );

    qsg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_phase),
        .o_beat  (w_vec)
    );

    qsg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_vec),
        .i_amp   (r_amp),
        .o_valid (o_valid),
        .o_real  (o_real_part),
        .o_imag  (o_imag_part)
    );

endmodule
